>>> rtl/euler_tour_next_edge_builder_defines.svh
// Assertion macros for the Euler-tour successor builder.
// Depends on nothing; the asserting module must have i_clk and i_rst_n.
`ifndef EULER_TOUR_NEXT_EDGE_BUILDER_DEFINES_SVH
`define EULER_TOUR_NEXT_EDGE_BUILDER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define ETNB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define ETNB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/etnb_pkg.sv
// Shared types and constants of the Euler-tour successor builder.
// Depends on nothing.
package etnb_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int PARENT_W      = 10;
    localparam int EDGE_W        = 11;
    localparam int CMDQ_DEPTH    = 2;
    localparam int RESQ_DEPTH    = 2;

    typedef logic [1:0] t_kind;

    localparam t_kind CMD_LOAD  = 2'd0;
    localparam t_kind CMD_LAST  = 2'd1;
    localparam t_kind CMD_QUERY = 2'd2;

    typedef struct packed {
        t_kind                kind;
        logic                 has_parent;
        logic [PARENT_W-1:0]  parent;
        logic [EDGE_W-1:0]    edge_req;
    } t_cmd;

    typedef struct packed {
        logic  valid;
        t_cmd  cmd;
    } t_cmdq;

    typedef struct packed {
        logic               next_valid;
        logic [EDGE_W-1:0]  next_edge;
        logic [EDGE_W-1:0]  first_edge;
    } t_res;

endpackage

>>> rtl/etnb_fifo.sv
// Small register queue used for the request and result paths.
// Depends on nothing.
module etnb_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_data o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data         r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          push_ok, pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count + CW'(push_ok) - CW'(pop_ok);
        if (push_ok) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/etnb_front.sv
// Front end: takes requests, classifies them and queues them for the back end.
// Depends on etnb_pkg and etnb_fifo.
module etnb_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_func,
    input  logic                           i_has_parent,
    input  logic [etnb_pkg::PARENT_W-1:0]  i_parent,
    input  logic                           i_last,
    input  logic [etnb_pkg::EDGE_W-1:0]    i_edge_req,
    input  logic                           i_hold,
    output logic                           o_full,
    output etnb_pkg::t_cmdq                o_cmdq,
    input  logic                           i_pop
);
    import etnb_pkg::*;

    t_cmd cmd_in;
    t_cmd q_data;
    logic q_full;
    logic q_empty;

    always_comb begin
        cmd_in.has_parent = i_has_parent;
        cmd_in.parent     = i_parent;
        cmd_in.edge_req   = i_edge_req;
        priority if (i_func) begin
            cmd_in.kind = CMD_QUERY;
        end else if (i_last) begin
            cmd_in.kind = CMD_LAST;
        end else begin
            cmd_in.kind = CMD_LOAD;
        end
    end

    assign o_full = q_full | i_hold;

    etnb_fifo #(
        .t_data (t_cmd),
        .DEPTH  (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push & ~o_full),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (i_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    assign o_cmdq.valid = ~q_empty;
    assign o_cmdq.cmd   = q_data;

endmodule

>>> rtl/etnb_back.sv
// Back end: parent store, child chains, successor store, build sequencer,
// query reads and the result queue. Depends on etnb_pkg, etnb_fifo and the defines header.
`include "euler_tour_next_edge_builder_defines.svh"

module etnb_back #(
    parameter int MAX_NODES = etnb_pkg::MAX_NODES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  etnb_pkg::t_cmdq  i_cmdq,
    output logic             o_pop,
    output logic             o_hold,
    output logic             o_empty,
    input  logic             i_pop,
    output etnb_pkg::t_res   o_res
);
    import etnb_pkg::*;

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CNTW = $clog2(MAX_NODES + 1);
    localparam int CW   = NW + 1;
    localparam int XW   = (CW > EDGE_W) ? CW : EDGE_W;
    localparam int PXW  = (CNTW > PARENT_W) ? CNTW : PARENT_W;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_Q    = 4'd2;
    localparam logic [3:0] S_A_RD = 4'd3;
    localparam logic [3:0] S_A_CH = 4'd4;
    localparam logic [3:0] S_A_WR = 4'd5;
    localparam logic [3:0] S_B_RD = 4'd6;
    localparam logic [3:0] S_B_W1 = 4'd7;
    localparam logic [3:0] S_B_W2 = 4'd8;

    typedef struct packed {
        logic                has_parent;
        logic [PARENT_W-1:0] parent;
    } t_pent;

    typedef struct packed {
        logic          valid;
        logic [NW-1:0] first;
        logic [NW-1:0] last;
    } t_centry;

    typedef struct packed {
        logic          valid;
        logic [CW-1:0] code;
    } t_sentry;

    t_pent   parent_mem [MAX_NODES];
    t_centry child_mem  [MAX_NODES];
    t_sentry succ_mem   [2*MAX_NODES];

    logic [3:0]      r_state, n_state;
    logic [NW-1:0]   r_idx, n_idx;
    logic [CNTW-1:0] r_count, n_count;
    logic            r_loading, n_loading;
    logic [CNTW-1:0] r_n, n_n;
    logic [CNTW-1:0] r_built, n_built;
    logic [CW-1:0]   r_tour, n_tour;
    logic            r_child, n_child;
    logic [NW-1:0]   r_pidx, n_pidx;
    logic [NW-1:0]   r_lc, n_lc;
    logic            r_inrange, n_inrange;

    t_pent   r_pdat;
    t_centry r_cdat;
    t_sentry r_sdat;

    logic            pm_we;
    logic [NW-1:0]   pm_wa;
    t_pent           pm_wd;
    logic [NW-1:0]   cm_ra;
    logic            cm_we;
    logic [NW-1:0]   cm_wa;
    t_centry         cm_wd;
    logic            sm_we;
    logic [CW-1:0]   sm_wa;
    t_sentry         sm_wd;
    logic [CW-1:0]   sm_ra;

    t_cmd            head;
    logic [CNTW-1:0] load_idx;
    logic [PXW-1:0]  p_ext;
    logic [XW-1:0]   e_ext;
    logic            last_node;
    logic            res_push;
    logic            res_full;
    t_res            res_data;
    logic            q_take;
    logic            walk_rd;

    assign head      = i_cmdq.cmd;
    assign load_idx  = r_loading ? r_count : '0;
    assign p_ext     = PXW'(r_pdat.parent);
    assign e_ext     = XW'(head.edge_req);
    assign last_node = (CNTW'(r_idx) == r_n - CNTW'(1));
    assign sm_ra     = e_ext[CW-1:0];
    assign res_push  = (r_state == S_Q);
    assign o_hold    = (r_state == S_INIT);
    assign q_take    = o_pop && (head.kind == CMD_QUERY);
    assign walk_rd   = (r_state == S_A_RD) || (r_state == S_B_RD);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_loading = r_loading;
        n_n       = r_n;
        n_built   = r_built;
        n_tour    = r_tour;
        n_child   = r_child;
        n_pidx    = r_pidx;
        n_lc      = r_lc;
        n_inrange = r_inrange;
        o_pop     = 1'b0;
        pm_we     = 1'b0;
        pm_wa     = load_idx[NW-1:0];
        pm_wd     = '{has_parent: head.has_parent, parent: head.parent};
        cm_ra     = r_idx;
        cm_we     = 1'b0;
        cm_wa     = r_idx;
        cm_wd     = '0;
        sm_we     = 1'b0;
        sm_wa     = {r_idx, 1'b0};
        sm_wd     = '0;
        unique case (r_state)
            S_INIT: begin
                cm_we = 1'b1;
                if (r_idx == NW'(MAX_NODES - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_cmdq.valid) begin
                    if (head.kind == CMD_QUERY) begin
                        if (!res_full) begin
                            o_pop     = 1'b1;
                            n_inrange = ({1'b0, e_ext} < (XW+1)'({r_built, 1'b0}));
                            n_state   = S_Q;
                        end
                    end else begin
                        o_pop     = 1'b1;
                        n_loading = 1'b1;
                        if (load_idx < CNTW'(MAX_NODES)) begin
                            pm_we   = 1'b1;
                            n_count = load_idx + 1'b1;
                        end else begin
                            n_count = load_idx;
                        end
                        if (head.kind == CMD_LAST) begin
                            n_loading = 1'b0;
                            n_n       = n_count;
                            n_idx     = '0;
                            n_tour    = '0;
                            n_state   = S_A_RD;
                        end
                    end
                end
            end
            S_Q: begin
                n_state = S_IDLE;
            end
            S_A_RD: begin
                n_state = S_A_CH;
            end
            S_A_CH: begin
                n_child = r_pdat.has_parent && (p_ext < PXW'(r_n));
                n_pidx  = p_ext[NW-1:0];
                cm_ra   = p_ext[NW-1:0];
                n_state = S_A_WR;
            end
            S_A_WR: begin
                sm_we = 1'b1;
                if (r_child) begin
                    cm_we = 1'b1;
                    cm_wa = r_pidx;
                    if (r_cdat.valid) begin
                        cm_wd = '{valid: 1'b1, first: r_cdat.first, last: r_idx};
                        sm_wa = {r_cdat.last, 1'b1};
                        sm_wd = '{valid: 1'b1, code: {r_idx, 1'b0}};
                    end else begin
                        cm_wd = '{valid: 1'b1, first: r_idx, last: r_idx};
                        sm_we = 1'b0;
                    end
                end else begin
                    sm_wa = {r_idx, 1'b1};
                end
                if (last_node) begin
                    n_idx   = '0;
                    n_state = S_B_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_A_RD;
                end
            end
            S_B_RD: begin
                n_state = S_B_W1;
            end
            S_B_W1: begin
                if (!r_pdat.has_parent) begin
                    n_tour = {r_idx, 1'b0};
                end
                sm_we = 1'b1;
                if (r_cdat.valid) begin
                    sm_wd = '{valid: 1'b1, code: {r_cdat.first, 1'b0}};
                end else begin
                    sm_wd = '{valid: 1'b1, code: {r_idx, 1'b1}};
                end
                cm_we = 1'b1;
                n_lc  = r_cdat.last;
                if (r_cdat.valid) begin
                    n_state = S_B_W2;
                end else if (last_node) begin
                    n_built = r_n;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_B_RD;
                end
            end
            S_B_W2: begin
                sm_we = 1'b1;
                sm_wa = {r_lc, 1'b1};
                sm_wd = '{valid: 1'b1, code: {r_idx, 1'b1}};
                if (last_node) begin
                    n_built = r_n;
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_B_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_idx     <= '0;
            r_count   <= '0;
            r_loading <= 1'b0;
            r_n       <= '0;
            r_built   <= '0;
            r_tour    <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_loading <= n_loading;
            r_n       <= n_n;
            r_built   <= n_built;
            r_tour    <= n_tour;
        end
    end

    always_ff @(posedge i_clk) begin
        r_child   <= n_child;
        r_pidx    <= n_pidx;
        r_lc      <= n_lc;
        r_inrange <= n_inrange;
    end

    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            parent_mem[pm_wa] <= pm_wd;
        end
        r_pdat <= parent_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            child_mem[cm_wa] <= cm_wd;
        end
        r_cdat <= child_mem[cm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            succ_mem[sm_wa] <= sm_wd;
        end
        r_sdat <= succ_mem[sm_ra];
    end

    always_comb begin
        res_data.next_valid = r_inrange & r_sdat.valid;
        res_data.next_edge  = res_data.next_valid ? EDGE_W'(r_sdat.code) : '0;
        res_data.first_edge = EDGE_W'(r_tour);
    end

    etnb_fifo #(
        .t_data (t_res),
        .DEPTH  (RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (o_res)
    );

    `ETNB_ASSERT_SAME(a_query_room, q_take, !res_full, "query taken without result room")
    `ETNB_ASSERT_NEXT(a_query_result, q_take, res_push, "query result not queued")
    `ETNB_ASSERT_SAME(a_busy_no_pop, r_state != S_IDLE, !o_pop, "request taken while busy")
    `ETNB_ASSERT_SAME(a_walk_range, walk_rd, CNTW'(r_idx) < r_n, "walk index beyond tree")

endmodule

>>> rtl/euler_tour_next_edge_builder.sv
// Euler-tour successor builder: loads a parent list, builds edge successors, answers queries.
// A query is read in S_IDLE and queued from S_Q before the next query; loads are taken one
// per cycle while in S_IDLE. Reset: synchronous, active low; S_INIT then clears the child store.
// Build after the last load: S_A_RD, S_A_CH and S_A_WR for each node, then S_B_RD and S_B_W1
// for each node, plus S_B_W2 for each node with children.
module euler_tour_next_edge_builder #(
    parameter int MAX_NODES = etnb_pkg::MAX_NODES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           i_func,
    input  logic                           i_has_parent,
    input  logic [etnb_pkg::PARENT_W-1:0]  i_parent,
    input  logic                           i_last,
    input  logic [etnb_pkg::EDGE_W-1:0]    i_edge_req,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_next_valid,
    output logic [etnb_pkg::EDGE_W-1:0]    o_next_edge,
    output logic [etnb_pkg::EDGE_W-1:0]    o_first_edge
);
    import etnb_pkg::*;

    t_cmdq cmdq;
    t_res  res;
    logic  cmd_pop;
    logic  hold;

    etnb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_func       (i_func),
        .i_has_parent (i_has_parent),
        .i_parent     (i_parent),
        .i_last       (i_last),
        .i_edge_req   (i_edge_req),
        .i_hold       (hold),
        .o_full       (full),
        .o_cmdq       (cmdq),
        .i_pop        (cmd_pop)
    );

    etnb_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmdq  (cmdq),
        .o_pop   (cmd_pop),
        .o_hold  (hold),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res)
    );

    assign o_next_valid = res.next_valid;
    assign o_next_edge  = res.next_edge;
    assign o_first_edge = res.first_edge;

endmodule
